[sv/ctp_pkg.sv]
// Shared types and constants for the Cartesian tree preorder block.
`default_nettype none

package ctp_pkg;

    // Largest block the design handles, and the field widths.
    localparam int unsigned MaxLen      = 8;
    localparam int unsigned ValueW      = 8;
    localparam int unsigned RankW       = 3;
    localparam int unsigned BlockLength = 8;

    typedef logic [ValueW-1:0] t_value;
    typedef logic [RankW-1:0]  t_rank;

    typedef t_value [MaxLen-1:0] t_value_arr;
    typedef t_rank  [MaxLen-1:0] t_rank_arr;

    // Input beat: one block of values.
    typedef struct packed {
        t_value value_0;
        t_value value_1;
        t_value value_2;
        t_value value_3;
        t_value value_4;
        t_value value_5;
        t_value value_6;
        t_value value_7;
    } t_in;

    // Output beat: positions in root, right, left preorder.
    typedef struct packed {
        t_rank order_0;
        t_rank order_1;
        t_rank order_2;
        t_rank order_3;
        t_rank order_4;
        t_rank order_5;
        t_rank order_6;
        t_rank order_7;
    } t_out;

endpackage

`default_nettype wire

[sv/cartesian_tree_preorder.sv]
// Top level: Cartesian tree preorder of an eight-value block, one beat per cycle.
//
//   Channel   Direction  Handshake           Payload
//   input     in         i_valid / o_stall   i_data  (t_in)
//   output    out        o_valid / i_stall   o_data  (t_out)
//
// Two register stages: the lanes' ranks, then the merged output. An accepted
// input beat passes through the rank stage, then the output stage, to o_valid,
// and a new beat is taken every cycle while the output side keeps up.
// Reset (i_rst_n low, synchronous) empties both stages.
// A stalled output holds its beat; the rank stage still takes one more beat,
// and o_stall rises only when both stages are full and the output is stalled.
`default_nettype none

module cartesian_tree_preorder
    import ctp_pkg::*;
#(
    parameter int unsigned BLOCK_LENGTH = BlockLength
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_stall,
    input  wire  t_in i_data,
    output logic o_valid,
    input  wire  i_stall,
    output t_out o_data
);

    // Block length held to the range the lanes support.
    localparam int unsigned BlockLen = (BLOCK_LENGTH > MaxLen) ? MaxLen :
                                       (BLOCK_LENGTH < 1) ? 1 : BLOCK_LENGTH;

    t_value_arr values;
    t_rank_arr  ranks;
    t_out       merged;

    t_rank_arr  r_rk;
    logic       r_rk_valid;
    t_out       r_out;
    logic       r_out_valid;

    logic       out_ld;
    logic       rk_ld;

    // Unpack the input beat into an indexable block.
    assign values[0] = i_data.value_0;
    assign values[1] = i_data.value_1;
    assign values[2] = i_data.value_2;
    assign values[3] = i_data.value_3;
    assign values[4] = i_data.value_4;
    assign values[5] = i_data.value_5;
    assign values[6] = i_data.value_6;
    assign values[7] = i_data.value_7;

    // One lane per live position; unused positions rank as zero.
    for (genvar g = 0; g < int'(MaxLen); g++) begin : g_lane
        if (g < int'(BlockLen)) begin : g_live
            ctp_lane #(
                .BLOCK_LENGTH(BlockLen),
                .POS         (g)
            ) u_lane (
                .i_values(values),
                .o_rank  (ranks[g])
            );
        end else begin : g_idle
            assign ranks[g] = '0;
        end
    end

    ctp_merge #(
        .BLOCK_LENGTH(BlockLen)
    ) u_merge (
        .i_ranks(r_rk),
        .o_order(merged)
    );

    // Stage advance: each stage loads when it is empty or its contents move on.
    assign out_ld  = !r_out_valid || !i_stall;
    assign rk_ld   = !r_rk_valid || out_ld;
    assign o_stall = !rk_ld;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Control state of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rk_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rk_ld) begin
                r_rk_valid <= i_valid;
            end
            if (out_ld) begin
                r_out_valid <= r_rk_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (rk_ld && i_valid) begin
            r_rk <= ranks;
        end
        if (out_ld && r_rk_valid) begin
            r_out <= merged;
        end
    end

endmodule

`default_nettype wire

[sv/ctp_lane.sv]
// One lane: finds the preorder rank of the node at a fixed block position.
`default_nettype none

module ctp_lane
    import ctp_pkg::*;
#(
    parameter int unsigned BLOCK_LENGTH = BlockLength,
    parameter int unsigned POS          = 0
) (
    input  wire t_value_arr i_values,
    output t_rank           o_rank
);

    // A node x is an ancestor of this node when x is the leftmost minimum of
    // the span between them. With right before left, every earlier position
    // that is an ancestor comes first, and every later position that is not
    // a descendant comes first.
    logic [RankW-1:0] cnt;
    logic             all_ge;
    logic             hit;

    always_comb begin
        cnt    = '0;
        all_ge = 1'b1;
        hit    = 1'b0;
        for (int x = 0; x < int'(MaxLen); x++) begin
            all_ge = 1'b1;
            hit    = 1'b0;
            if (x < int'(BLOCK_LENGTH) && x != int'(POS)) begin
                if (x < int'(POS)) begin
                    // Earlier x is an ancestor when nothing in (x, POS] is below it.
                    for (int k = 0; k < int'(MaxLen); k++) begin
                        if (k > x && k <= int'(POS) && i_values[k] < i_values[x]) begin
                            all_ge = 1'b0;
                        end
                    end
                    hit = all_ge;
                end else begin
                    // Later x is a descendant when nothing in (POS, x] is below us.
                    for (int k = 0; k < int'(MaxLen); k++) begin
                        if (k > int'(POS) && k <= x && i_values[k] < i_values[POS]) begin
                            all_ge = 1'b0;
                        end
                    end
                    hit = !all_ge;
                end
            end
            cnt = cnt + RankW'(hit);
        end
    end

    assign o_rank = cnt;

endmodule

`default_nettype wire

[sv/ctp_merge.sv]
// Merge stage: scatters the lane ranks into the preorder position list.
`default_nettype none

module ctp_merge
    import ctp_pkg::*;
#(
    parameter int unsigned BLOCK_LENGTH = BlockLength
) (
    input  wire t_rank_arr i_ranks,
    output t_out           o_order
);

    t_rank_arr order;

    // Ranks of the live positions form a permutation, so each slot gets one
    // writer; slots past the block length stay zero.
    always_comb begin
        order = '0;
        for (int j = 0; j < int'(BLOCK_LENGTH); j++) begin
            order[i_ranks[j]] = RankW'(j);
        end
    end

    assign o_order.order_0 = order[0];
    assign o_order.order_1 = order[1];
    assign o_order.order_2 = order[2];
    assign o_order.order_3 = order[3];
    assign o_order.order_4 = order[4];
    assign o_order.order_5 = order[5];
    assign o_order.order_6 = order[6];
    assign o_order.order_7 = order[7];

endmodule

`default_nettype wire
